FILE: design/sorted_insert_priority_queue_defines.svh
// assertion macros shared by the checker
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SIPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sipq assertion failed");

// next-cycle implication, disabled during reset
`define SIPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sipq assertion failed");

// next-cycle implication that also holds across reset
`define SIPQ_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sipq assertion failed");

`endif

FILE: design/sipq_pkg.sv
`timescale 1ns / 1ps
package sipq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  priority_req;
        logic [15:0] name_tag;
        logic [15:0] symptom_tag;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [7:0]  out_priority;
        logic [15:0] out_name_tag;
        logic [15:0] out_symptom_tag;
        logic [3:0]  occupancy;
    } t_out_req;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] name;
        logic [15:0] symptom;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

FILE: design/sipq_cell.sv
`timescale 1ns / 1ps
module sipq_cell (
    input  logic                  i_clk,
    input  sipq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_occ,
    input  logic                  i_prev_ge,
    input  sipq_pkg::t_entry      i_prev,
    input  sipq_pkg::t_entry      i_next,
    output logic                  o_ge,
    output sipq_pkg::t_entry      o_entry
);

    sipq_pkg::t_entry r_entry;

    // held entry stays ahead of the new one on equal priority
    assign o_ge    = i_occ && (r_entry.prio >= i_ctrl.new_entry.prio);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.enq) begin
            if (!o_ge) begin
                r_entry <= i_prev_ge ? i_ctrl.new_entry : i_prev;
            end
        end else if (i_ctrl.deq) begin
            r_entry <= i_next;
        end
    end

endmodule

FILE: design/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps
// Sorted priority queue of DEPTH entries, highest priority at the head.
// Input channel (i_in_valid / o_in_stall, payload i_in_req): each request is
// an enqueue (cmd 0) or a dequeue (cmd 1). Equal priorities leave in arrival
// order. Output channel (o_out_valid / i_out_stall, payload o_out_req): one
// result per request carrying status, the dequeued entry and the occupancy.
// A request accepted at an edge has its result on the output register from
// that edge on. Throughput is one request per cycle while the receiver does
// not stall; every cell of the shift chain compares against the new priority
// at once, so insert or remove finishes in the accepting cycle.
// While the receiver stalls, the result is held and a new request is only
// taken when the output register is free, so o_in_stall follows i_out_stall
// whenever a result is waiting.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; slot contents are not cleared.
module sorted_insert_priority_queue #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sipq_pkg::t_in_req  i_in_req,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sipq_pkg::t_out_req o_out_req,
    input  logic               i_out_stall
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    sipq_pkg::t_out_req   r_out_req, n_out_req;

    logic                 accept, full, empty, do_enq, do_deq;
    sipq_pkg::t_cell_ctrl ctrl;
    logic [DEPTH-1:0]     ge;
    sipq_pkg::t_entry     entry [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign do_enq     = accept && (i_in_req.cmd == sipq_pkg::CMD_ENQ) && !full;
    assign do_deq     = accept && (i_in_req.cmd == sipq_pkg::CMD_DEQ) && !empty;

    always_comb begin
        ctrl.enq               = do_enq;
        ctrl.deq               = do_deq;
        ctrl.new_entry.prio    = i_in_req.priority_req;
        ctrl.new_entry.name    = i_in_req.name_tag;
        ctrl.new_entry.symptom = i_in_req.symptom_tag;
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic             prev_ge;
        sipq_pkg::t_entry prev_entry;
        sipq_pkg::t_entry next_entry;

        if (k == 0) begin : g_head
            // head cell takes the new entry whenever it is not ahead of it
            assign prev_ge    = 1'b1;
            assign prev_entry = ctrl.new_entry;
        end else begin : g_body
            assign prev_ge    = ge[k-1];
            assign prev_entry = entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign next_entry = entry[k];
        end else begin : g_mid
            assign next_entry = entry[k+1];
        end

        sipq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (ctrl),
            .i_occ     (CW'(k) < r_count),
            .i_prev_ge (prev_ge),
            .i_prev    (prev_entry),
            .i_next    (next_entry),
            .o_ge      (ge[k]),
            .o_entry   (entry[k])
        );
    end

    always_comb begin
        n_count = r_count;
        if (do_enq) begin
            n_count = r_count + CW'(1);
        end else if (do_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_req                 = '0;
        n_out_req.status          = sipq_pkg::STATUS_OK;
        n_out_req.occupancy       = 4'(n_count);
        if (i_in_req.cmd == sipq_pkg::CMD_ENQ) begin
            if (full) begin
                n_out_req.status = sipq_pkg::STATUS_FULL;
            end
        end else if (empty) begin
            n_out_req.status = sipq_pkg::STATUS_EMPTY;
        end else begin
            n_out_req.out_valid       = 1'b1;
            n_out_req.out_priority    = entry[0].prio;
            n_out_req.out_name_tag    = entry[0].name;
            n_out_req.out_symptom_tag = entry[0].symptom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

FILE: design/sipq_checker.sv
`timescale 1ns / 1ps
`include "sorted_insert_priority_queue_defines.svh"
module sipq_checker #(
    parameter int DEPTH = sipq_pkg::DEPTH_DEFAULT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input sipq_pkg::t_out_req o_out_req,
    input logic               i_out_stall
);

    localparam logic [3:0] OCC_FULL = 4'(DEPTH);
    localparam logic       OCC_EXACT = (DEPTH <= 15);

    // a stalled result stays put
    `SIPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_req))
    // a returned entry always comes with ok status
    `SIPQ_ASSERT_NOW(a_deq_ok, i_clk, i_rst_n, o_out_valid && o_out_req.out_valid, o_out_req.status == sipq_pkg::STATUS_OK)
    // full refusal reports a full queue
    `SIPQ_ASSERT_NOW(a_full_occ, i_clk, i_rst_n, o_out_valid && (o_out_req.status == sipq_pkg::STATUS_FULL), o_out_req.occupancy == OCC_FULL)
    // occupancy never exceeds the depth
    `SIPQ_ASSERT_NOW(a_occ_max, i_clk, i_rst_n, o_out_valid && OCC_EXACT, o_out_req.occupancy <= OCC_FULL)
    // reset drops any pending result
    `SIPQ_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind sorted_insert_priority_queue sipq_checker #(.DEPTH(DEPTH)) u_sipq_checker (.*);
